### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the longest-queue arbiter.
// Depends on nothing; the files that assert include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// A condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed: condition does not hold");
// An antecedent that implies a consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: implication does not hold");
// An antecedent that implies a consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication does not hold");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/lqa_pkg.sv
// Shared types and constants of the longest-queue arbiter.
// Used by lqa_queues and the top level; depends on nothing.
package lqa_pkg;

  localparam int NUM_Q       = 4;
  localparam int QUEUE_DEPTH = 16;
  localparam int ID_BITS     = 16;
  localparam int LIMIT_RESET = 10;

  localparam int SEC_W   = $clog2(NUM_Q);
  localparam int SLOT_W  = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int TOTAL_W = $clog2(NUM_Q * QUEUE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(NUM_Q * QUEUE_DEPTH);
  localparam int LIMIT_W = 4;

  // Request kinds on the input tuser.
  typedef enum logic {
    ACT_ARRIVE = 1'b0,
    ACT_SERVE  = 1'b1
  } action_e;

  // Result codes on the output tuser.
  typedef enum logic [2:0] {
    ST_QUEUED   = 3'd0,
    ST_REJECT   = 3'd1,
    ST_OVERLOAD = 3'd2,
    ST_SERVED   = 3'd3,
    ST_IDLE     = 3'd4,
    ST_CLEARED  = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_OVERLOAD_LIMIT = 1'b0,
    REG_UNUSED         = 1'b1
  } reg_idx_e;

  // One stored queue entry.
  typedef struct packed {
    logic [ID_BITS-1:0] id;
    logic               is_long;
  } entry_t;

  // Push/pop command from the control logic to the queue bank.
  typedef struct packed {
    logic             push;
    logic             pop;
    logic [SEC_W-1:0] sec;
    entry_t           entry;
  } q_cmd_t;

  // Occupancy view of the queue bank.
  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               full;
    logic [SEC_W-1:0]   best;
  } q_stat_t;

endpackage

### rtl/lqa_queues.sv
// Bank of four circular FIFOs in one shared store, with per-queue head and count.
// Depends on lqa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lqa_queues
  import lqa_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  q_cmd_t  cmd_i,
  output q_stat_t stat_o,
  output entry_t  rd_entry_o
);

  localparam int SUM_W = CNT_W + 1;

  logic [SLOT_W-1:0] heads_q [NUM_Q];
  logic [SLOT_W-1:0] heads_d [NUM_Q];
  logic [CNT_W-1:0]  cnt_q   [NUM_Q];
  logic [CNT_W-1:0]  cnt_d   [NUM_Q];
  logic [SLOT_W-1:0] tail_slot [NUM_Q];
  logic [SLOT_W-1:0] head_next [NUM_Q];
  logic [NUM_Q-1:0]  full_vec;

  logic [SEC_W-1:0]   best;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W-1:0]  wr_addr;
  logic [ADDR_W-1:0]  rd_addr;

  entry_t store_mem [NUM_Q*QUEUE_DEPTH];
  entry_t rd_entry_q;

  // Per-queue tail slot, advanced head and full flag.
  for (genvar q = 0; q < NUM_Q; q++) begin : g_lane
    logic [SUM_W-1:0] tail_sum;
    assign tail_sum = SUM_W'(heads_q[q]) + SUM_W'(cnt_q[q]);
    assign tail_slot[q] = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                          SLOT_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
    assign head_next[q] = (heads_q[q] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                          '0 : heads_q[q] + SLOT_W'(1);
    assign full_vec[q]  = (cnt_q[q] == CNT_W'(QUEUE_DEPTH));
  end

  // Longest queue, ties to the lowest index, and the total occupancy.
  always_comb begin
    best  = '0;
    total = '0;
    for (int q = 0; q < NUM_Q; q++) begin
      total = total + TOTAL_W'(cnt_q[q]);
    end
    for (int q = 1; q < NUM_Q; q++) begin
      if (cnt_q[q] > cnt_q[best]) begin
        best = SEC_W'(q);
      end
    end
  end

  assign wr_addr = ADDR_W'(cmd_i.sec) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_slot[cmd_i.sec]);
  assign rd_addr = ADDR_W'(best) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(heads_q[best]);

  // Next head and count of every queue.
  always_comb begin
    for (int q = 0; q < NUM_Q; q++) begin
      heads_d[q] = heads_q[q];
      cnt_d[q]   = cnt_q[q];
      if (cmd_i.push && (cmd_i.sec == SEC_W'(q))) begin
        cnt_d[q] = cnt_q[q] + CNT_W'(1);
      end
      if (cmd_i.pop && (best == SEC_W'(q))) begin
        heads_d[q] = head_next[q];
        cnt_d[q]   = cnt_q[q] - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int q = 0; q < NUM_Q; q++) begin
        heads_q[q] <= '0;
        cnt_q[q]   <= '0;
      end
    end else begin
      heads_q <= heads_d;
      cnt_q   <= cnt_d;
    end
  end

  // Shared entry store: one write port for arrivals, one registered read for serves.
  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      store_mem[wr_addr] <= cmd_i.entry;
    end
    if (cmd_i.pop) begin
      rd_entry_q <= store_mem[rd_addr];
    end
  end

  assign stat_o.total = total;
  assign stat_o.full  = full_vec[cmd_i.sec];
  assign stat_o.best  = best;
  assign rd_entry_o   = rd_entry_q;

  `ASSERT_IMPLIES(a_pop_not_empty, clk_i, rst_ni, cmd_i.pop, total != '0)
  `ASSERT_IMPLIES(a_push_not_full, clk_i, rst_ni, cmd_i.push, !full_vec[cmd_i.sec])
  `ASSERT_NEXT(a_push_grows_total, clk_i, rst_ni, cmd_i.push && !cmd_i.pop,
               total == $past(total) + TOTAL_W'(1))

endmodule

### rtl/longest_queue_arbiter_with_drain_unit.sv
// Top level of the longest-queue-first arbiter with overload drain.
// Depends on lqa_pkg, lqa_queues and assert_macros.svh.
//
// Requests arrive on the s_axis channel: tuser carries the kind (arrival or
// serve), tdata the section and length class of an arrival. Every request
// gives exactly one result on the m_axis channel: tuser carries the status,
// tdata the item id, the served section and class, the drain flag and the
// total number of queued items after the request.
// A request is decided in the cycle it is accepted, from the queue counters,
// and its result is registered; the id of a served item comes out of the
// shared store's registered read port at the same edge. One request is
// accepted every cycle while the output is taken. When the receiver stalls,
// the result register holds and s_axis_tready falls until the result is
// taken; a result is replaced in the cycle it leaves. After reset all queues
// are empty, drain is off, the next id is 0 and the overload limit is 10; no
// clearing pass is needed.
// The APB port holds the overload limit at byte address 0.
`include "assert_macros.svh"

module longest_queue_arbiter_with_drain_unit
  import lqa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] section, [2] is_long, [7:3] zero
  input  logic [0:0]  s_axis_tuser,   // [0] action
  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] item_id, [17:16] served_section, [18] served_long, [19] draining,
  // [26:20] total_waiting, [31:27] zero
  output logic [31:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  // Configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic               out_valid_q;
  status_e            status_q, status_d;
  logic [ID_BITS-1:0] qid_q, qid_d;
  logic [SEC_W-1:0]   sec_q;
  logic               drain_q, drain_d;
  logic [ID_BITS-1:0] next_id_q, next_id_d;
  logic [LIMIT_W-1:0] limit_q;

  logic       in_accept;
  action_e    action;
  q_cmd_t     cmd;
  q_stat_t    stat;
  entry_t     rd_entry;
  reg_idx_e   reg_idx;
  logic       served;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[2]);

  // Limit register write and read back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite && pready && (reg_idx == REG_OVERLOAD_LIMIT)) begin
      limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OVERLOAD_LIMIT: prdata = 32'(limit_q);
      default:            prdata = '0;
    endcase
  end

  // Accept a new request whenever the result register is free or being emptied.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign action        = action_e'(s_axis_tuser[0]);

  lqa_queues u_queues (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rd_entry_o (rd_entry)
  );

  // Request decision: admission, drain control and serve.
  always_comb begin
    cmd.push          = 1'b0;
    cmd.pop           = 1'b0;
    cmd.sec           = s_axis_tdata[SEC_W-1:0];
    cmd.entry.id      = next_id_q;
    cmd.entry.is_long = s_axis_tdata[2];
    status_d          = ST_IDLE;
    qid_d             = '0;
    drain_d           = drain_q;
    next_id_d         = next_id_q;
    case (action)
      ACT_ARRIVE: begin
        if (drain_q) begin
          status_d = ST_REJECT;
        end else if (stat.total > TOTAL_W'(limit_q)) begin
          status_d = ST_OVERLOAD;
          drain_d  = 1'b1;
        end else if (stat.full) begin
          status_d = ST_FULL;
        end else begin
          status_d  = ST_QUEUED;
          cmd.push  = in_accept;
          qid_d     = next_id_q;
          next_id_d = next_id_q + ID_BITS'(1);
        end
      end
      ACT_SERVE: begin
        if (stat.total == '0) begin
          status_d = drain_q ? ST_CLEARED : ST_IDLE;
          drain_d  = 1'b0;
        end else begin
          status_d = ST_SERVED;
          cmd.pop  = in_accept;
        end
      end
      default: begin
        status_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      drain_q     <= 1'b0;
      next_id_q   <= '0;
    end else begin
      if (in_accept) begin
        out_valid_q <= 1'b1;
        drain_q     <= drain_d;
        next_id_q   <= next_id_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      status_q <= status_d;
      qid_q    <= qid_d;
      sec_q    <= stat.best;
    end
  end

  // Result fields; the served entry comes straight from the store's read register.
  assign served        = (status_q == ST_SERVED);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {5'b0,
                          7'(stat.total),
                          drain_q,
                          served ? rd_entry.is_long : 1'b0,
                          served ? sec_q : SEC_W'(0),
                          served ? 16'(rd_entry.id) : 16'(qid_q)};

  `ASSERT_IMPLIES(a_cleared_means_empty, clk_i, rst_ni,
                  out_valid_q && (status_q == ST_CLEARED), !drain_q && (stat.total == '0))
  `ASSERT_IMPLIES(a_overload_sets_drain, clk_i, rst_ni,
                  out_valid_q && (status_q == ST_OVERLOAD), drain_q)
  `ASSERT_NEXT(a_queued_takes_id, clk_i, rst_ni, in_accept && cmd.push,
               next_id_q == $past(next_id_q) + ID_BITS'(1))

endmodule

### verif/longest_queue_arbiter_with_drain_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for longest_queue_arbiter_with_drain_unit.
// A scoreboard class predicts each result from the accepted requests; plain tasks
// drive the stream and APB ports. Depends on lqa_pkg and the unit's RTL.

module longest_queue_arbiter_with_drain_unit_tb;
  import lqa_pkg::*;

  localparam int HOLD_CYCLES      = 300;
  localparam int STALL_LIMIT      = 3000;
  localparam int RANDOM_PER_LIMIT = 250;
  localparam int SEGMENT_LEN      = 25;
  localparam int WRAP_PAIRS       = 20;

  // One predicted result, field by field.
  typedef struct {
    status_e     status;
    logic [15:0] item_id;
    logic [1:0]  sec;
    logic        lng;
    logic        drain;
    logic [6:0]  total;
  } outcome_t;

  // Mirror of the arbiter state plus the list of results still to come.
  class lqf_scoreboard;
    entry_t             waiting[NUM_Q][$];
    logic               drain;
    logic [ID_BITS-1:0] next_id;
    logic [LIMIT_W-1:0] limit;
    outcome_t           outstanding[$];
    int                 errors;
    int                 requests;
    int                 wraps;
    int                 status_seen[8];

    function new();
      drain    = 1'b0;
      next_id  = '0;
      limit    = LIMIT_W'(LIMIT_RESET);
      errors   = 0;
      requests = 0;
      wraps    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int queued_total();
      int sum;
      sum = 0;
      for (int q = 0; q < NUM_Q; q++) sum += waiting[q].size();
      return sum;
    endfunction

    function int pending();
      return outstanding.size();
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    // Work out the result of one accepted request and update the mirror.
    function void note_request(action_e act, logic [SEC_W-1:0] sec, logic lng);
      outcome_t o;
      entry_t   e;
      int       best;
      o = '{status: ST_IDLE, item_id: '0, sec: '0, lng: 1'b0, drain: 1'b0, total: '0};
      requests++;
      if (act == ACT_ARRIVE) begin
        // Drain mode refuses everything; overload is tested before fullness, so
        // with a 4-bit limit a queue never reports full.
        if (drain) begin
          o.status = ST_REJECT;
        end else if (queued_total() > limit) begin
          drain    = 1'b1;
          o.status = ST_OVERLOAD;
        end else if (waiting[sec].size() >= QUEUE_DEPTH) begin
          o.status = ST_FULL;
        end else begin
          e.id      = next_id;
          e.is_long = lng;
          waiting[sec].push_back(e);
          o.status  = ST_QUEUED;
          o.item_id = 16'(next_id);
          next_id   = next_id + ID_BITS'(1);
          if (next_id == '0) wraps++;
        end
      end else if (queued_total() == 0) begin
        o.status = drain ? ST_CLEARED : ST_IDLE;
        drain    = 1'b0;
      end else begin
        // Longest queue wins; the strict compare keeps ties on the lowest index.
        best = 0;
        for (int q = 1; q < NUM_Q; q++)
          if (waiting[q].size() > waiting[best].size()) best = q;
        e         = waiting[best].pop_front();
        o.status  = ST_SERVED;
        o.item_id = 16'(e.id);
        o.sec     = SEC_W'(best);
        o.lng     = e.is_long;
      end
      o.drain = drain;
      o.total = 7'(queued_total());
      outstanding.push_back(o);
    endfunction

    function void compare_field(string name, logic [15:0] expected, logic [15:0] actual);
      if (actual !== expected) begin
        $error("%s: expected %0d, got %0d", name, expected, actual);
        errors++;
      end
    endfunction

    // Check one accepted result against the oldest prediction.
    function void check_result(logic [2:0] st, logic [31:0] data);
      outcome_t o;
      if (outstanding.size() == 0) begin
        $error("result with no request outstanding: status %0d, data 0x%08h", st, data);
        errors++;
        return;
      end
      o = outstanding.pop_front();
      if (!$isunknown(st)) status_seen[st]++;
      compare_field("status", 16'(o.status), 16'(st));
      compare_field("item_id", o.item_id, data[15:0]);
      compare_field("served_section", 16'(o.sec), 16'(data[17:16]));
      compare_field("served_long", 16'(o.lng), 16'(data[18]));
      compare_field("draining", 16'(o.drain), 16'(data[19]));
      compare_field("total_waiting", 16'(o.total), 16'(data[26:20]));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [1:0] section, [2] is_long, [7:3] zero
  logic [0:0]  s_axis_tuser;   // [0] action
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  // [15:0] item_id, [17:16] served_section, [18] served_long, [19] draining,
  // [26:20] total_waiting, [31:27] zero
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;   // [2:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lqf_scoreboard sb = new();
  bit            calm = 1'b0;
  bit            hold_req = 1'b0;
  int            idle_cycles = 0;

  longest_queue_arbiter_with_drain_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Offer one request, with an occasional gap before it, and note it once accepted.
  task automatic send_req(input action_e act, input logic [SEC_W-1:0] sec, input logic lng);
    if (!calm && $urandom_range(99) < 8) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, lng, sec};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(act, sec, lng);
  endtask

  // Write the overload limit once every outstanding result has come back.
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OVERLOAD_LIMIT, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_limit(value);
  endtask

  // Result side: random back-pressure, one long hold-off on request, checking.
  initial begin
    m_axis_tready <= 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      m_axis_tready <= calm || ($urandom_range(99) >= 8);
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus.
  initial begin
    logic [LIMIT_W-1:0] limits[6];
    int                 arrive_pct;
    logic [SEC_W-1:0]   favored;
    logic [SEC_W-1:0]   sec;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= ACT_ARRIVE;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: idle serve, longest-queue and tie choice, both classes.
    send_req(ACT_SERVE, 2'd3, 1'b1);
    send_req(ACT_ARRIVE, 2'd0, 1'b0);
    send_req(ACT_ARRIVE, 2'd3, 1'b1);
    send_req(ACT_ARRIVE, 2'd3, 1'b0);
    send_req(ACT_SERVE, 2'd0, 1'b0);
    send_req(ACT_SERVE, 2'd1, 1'b0);
    send_req(ACT_SERVE, 2'd2, 1'b1);
    send_req(ACT_SERVE, 2'd0, 1'b0);

    // Directed: limit zero, overload entry, rejection, serve while draining, clear.
    write_limit(4'd0);
    send_req(ACT_ARRIVE, 2'd1, 1'b1);
    send_req(ACT_ARRIVE, 2'd2, 1'b0);
    send_req(ACT_ARRIVE, 2'd2, 1'b1);
    send_req(ACT_SERVE, 2'd0, 1'b0);
    send_req(ACT_SERVE, 2'd0, 1'b0);
    send_req(ACT_SERVE, 2'd0, 1'b0);

    // A short run of arrive/serve pairs at full rate.
    write_limit(4'd15);
    calm = 1'b1;
    for (int n = 0; n < WRAP_PAIRS; n++) begin
      send_req(ACT_ARRIVE, SEC_W'($urandom_range(3)), 1'($urandom_range(1)));
      send_req(ACT_SERVE, SEC_W'($urandom_range(3)), 1'($urandom_range(1)));
    end
    calm = 1'b0;

    // Random phases over several limits; arrival share and a favored queue
    // change every 25 requests so queues grow uneven and overload occurs.
    limits = '{4'd15, 4'd0, 4'd7, 4'd10, 4'd1, 4'd12};
    limits[2] = LIMIT_W'($urandom_range(15));
    limits[4] = LIMIT_W'($urandom_range(15));
    for (int s = 0; s < 6; s++) begin
      write_limit(limits[s]);
      calm = (s == 3);
      if (s == 0) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_LIMIT; n++) begin
        if (n % SEGMENT_LEN == 0) begin
          arrive_pct = $urandom_range(15, 85);
          favored    = SEC_W'($urandom_range(3));
        end
        sec = $urandom_range(1) ? favored : SEC_W'($urandom_range(3));
        send_req(($urandom_range(99) < arrive_pct) ? ACT_ARRIVE : ACT_SERVE, sec,
                 1'($urandom_range(1)));
      end
    end
    calm = 1'b0;

    // Drain the pipeline and finish.
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    $display("Run covered %0d requests over limits 0..15, id wrapped %0d time(s).",
             sb.requests, sb.wraps);
    $display("Results: queued %0d, served %0d, overload %0d, rejected %0d, cleared %0d, idle %0d.",
             sb.status_seen[ST_QUEUED], sb.status_seen[ST_SERVED],
             sb.status_seen[ST_OVERLOAD], sb.status_seen[ST_REJECT],
             sb.status_seen[ST_CLEARED], sb.status_seen[ST_IDLE]);
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/lqa_pkg.sv
rtl/lqa_queues.sv
rtl/longest_queue_arbiter_with_drain_unit.sv
verif/longest_queue_arbiter_with_drain_unit_tb.sv
